// ----- design/demand_paging_frame_manager_assert.svh -----
// Assertion macros used by the frame manager datapath.
`ifndef DEMAND_PAGING_FRAME_MANAGER_ASSERT_SVH
`define DEMAND_PAGING_FRAME_MANAGER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DPFM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DPFM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/dpfm_pkg.sv -----
// Types and constants of the demand-paging frame manager.
`timescale 1ns / 1ps
package dpfm_pkg;

   localparam int ACTION_W = 2;
   localparam int PROC_W   = 4;
   localparam int PAGE_W   = 11;
   localparam int FRAME_W  = 14;
   localparam int STATUS_W = 3;
   localparam int ACTIVE_W = 5;
   localparam int COUNT_W  = 32;
   localparam int LEAST_W  = 5;
   localparam logic [LEAST_W-1:0] NO_SWAP_YET = 5'd31;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADMIT    = 2'd0,
      ACT_ACCESS   = 2'd1,
      ACT_COMPLETE = 2'd2,
      ACT_INVALID  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT          = 3'd0,
      ST_FAULT        = 3'd1,
      ST_SWAPPED      = 3'd2,
      ST_ADMITTED     = 3'd3,
      ST_COMPLETED    = 3'd4,
      ST_SWAPIN       = 3'd5,
      ST_NO_FRAMES    = 3'd6,
      ST_NOT_RESIDENT = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      MODE_NONE     = 2'd0,
      MODE_RESIDENT = 2'd1,
      MODE_SWAPPED  = 2'd2,
      MODE_DONE     = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_ACC_CHK,
      S_FAULT_WR,
      S_REL_RD,
      S_REL_WR,
      S_REL_END,
      S_SWAPIN_CHK,
      S_MAP_RD,
      S_MAP_WR,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       clear_step;
      logic       ptr_reset;
      logic       ptr_inc;
      logic       page_rd_access;
      logic       map_write;
      logic       fault_write;
      logic       release_write;
      logic       count_access;
      logic       count_fault;
      logic       hit_capture;
      logic       finish_admit;
      logic       finish_swapout;
      logic       finish_complete;
      logic       do_swapin;
      logic       set_status;
      status_type status;
      logic       result_load;
   } cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic       req_valid;
      action_type action;
      logic       proc_ok;
      logic       page_ok;
      mode_type   mode;
      logic       free_ge_ess;
      logic       free_nonzero;
      logic       page_valid;
      logic       sweep_last;
      logic       map_last;
      logic       swap_pending;
      logic       rsp_free;
   } stat_type;

endpackage

// ----- design/dpfm_if.sv -----
// Item channels of the frame manager: request and response.
`timescale 1ns / 1ps
interface dpfm_req_if;
   logic                          valid;
   logic                          ready;
   logic [dpfm_pkg::ACTION_W-1:0] action;
   logic [dpfm_pkg::PROC_W-1:0]   process;
   logic [dpfm_pkg::PAGE_W-1:0]   page;
   modport source (output valid, action, process, page, input ready);
   modport sink (input valid, action, process, page, output ready);
endinterface

interface dpfm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dpfm_pkg::STATUS_W-1:0] status;
   logic [dpfm_pkg::FRAME_W-1:0]  frame;
   logic [dpfm_pkg::PROC_W-1:0]   swapped_in_process;
   logic [dpfm_pkg::ACTIVE_W-1:0] active_processes;
   logic [dpfm_pkg::COUNT_W-1:0]  access_total;
   logic [dpfm_pkg::COUNT_W-1:0]  fault_total;
   logic [dpfm_pkg::COUNT_W-1:0]  swap_total;
   logic [dpfm_pkg::LEAST_W-1:0]  min_active;
   modport source (output valid, status, frame, swapped_in_process, active_processes,
                   access_total, fault_total, swap_total, min_active, input ready);
   modport sink (input valid, status, frame, swapped_in_process, active_processes,
                 access_total, fault_total, swap_total, min_active, output ready);
endinterface

// ----- design/demand_paging_frame_manager.sv -----
// Top level of the demand-paging frame manager.
`timescale 1ns / 1ps
// After reset the block runs a clearing pass that empties the page tables and fills the
// free-frame FIFO; no request is taken during it. Requests are then handled one at a time
// by a sequencer over two single-port-per-side RAMs. A rejected request goes from decode
// straight to the result; a hit reads the page table, and a fault that maps a frame writes
// it into the table. An admit maps ESSENTIAL_PAGES pages, and a swap-out or completion
// walks the whole page table of the process, reading and then writing each page; a
// completion maps ESSENTIAL_PAGES pages more when a swapped process comes back. A stalled
// response holds the sequencer until its output register frees up. A finished result
// waits in that register, so the next request is accepted while it is still pending.
module demand_paging_frame_manager #(
   parameter int PROCS           = 16,
   parameter int PAGES           = 2048,
   parameter int RESERVED_FRAMES = 4096,
   parameter int NUM_FRAMES      = 16384,
   parameter int ESSENTIAL_PAGES = 10
) (
   input logic        clock,
   input logic        reset,
   dpfm_req_if.sink   req_if,
   dpfm_rsp_if.source rsp_if
);
   dpfm_pkg::cmd_type  cmd;
   dpfm_pkg::stat_type stat;

   dpfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_if.ready)
   );

   dpfm_datapath #(
      .PROCS           (PROCS),
      .PAGES           (PAGES),
      .RESERVED_FRAMES (RESERVED_FRAMES),
      .NUM_FRAMES      (NUM_FRAMES),
      .ESSENTIAL_PAGES (ESSENTIAL_PAGES)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (stat),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );
endmodule

// ----- design/dpfm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dpfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/dpfm_ctrl.sv -----
// Sequencer of the frame manager: walks each request through its steps.
`timescale 1ns / 1ps
module dpfm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  dpfm_pkg::stat_type stat,
   output dpfm_pkg::cmd_type  cmd,
   output logic               req_ready
);
   dpfm_pkg::state_type state_ff, state_in;
   logic rel_swap_ff, rel_swap_in;    // release pass belongs to a swap-out
   logic map_swapin_ff, map_swapin_in; // map pass belongs to a swap-in

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dpfm_pkg::S_CLEAR;
         rel_swap_ff   <= 1'b0;
         map_swapin_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rel_swap_ff   <= rel_swap_in;
         map_swapin_ff <= map_swapin_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      rel_swap_in   = rel_swap_ff;
      map_swapin_in = map_swapin_ff;
      cmd           = '0;
      cmd.status    = dpfm_pkg::ST_NOT_RESIDENT;
      req_ready     = 1'b0;
      case (state_ff)
         dpfm_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = dpfm_pkg::S_IDLE;
            end
         end
         dpfm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            // Take the item only when one is offered.
            if (stat.req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = dpfm_pkg::S_DECODE;
            end
         end
         dpfm_pkg::S_DECODE: begin
            cmd.set_status = 1'b1;
            state_in       = dpfm_pkg::S_RESULT;
            case (stat.action)
               dpfm_pkg::ACT_ADMIT: begin
                  if (!stat.proc_ok || stat.mode != dpfm_pkg::MODE_NONE) begin
                     cmd.status = dpfm_pkg::ST_NOT_RESIDENT;
                  end else if (!stat.free_ge_ess) begin
                     cmd.status = dpfm_pkg::ST_NO_FRAMES;
                  end else begin
                     cmd.set_status = 1'b0;
                     cmd.ptr_reset  = 1'b1;
                     map_swapin_in  = 1'b0;
                     state_in       = dpfm_pkg::S_MAP_RD;
                  end
               end
               dpfm_pkg::ACT_ACCESS: begin
                  if (!stat.proc_ok || !stat.page_ok ||
                      stat.mode != dpfm_pkg::MODE_RESIDENT) begin
                     cmd.status = dpfm_pkg::ST_NOT_RESIDENT;
                  end else begin
                     cmd.set_status     = 1'b0;
                     cmd.count_access   = 1'b1;
                     cmd.page_rd_access = 1'b1;
                     state_in           = dpfm_pkg::S_ACC_CHK;
                  end
               end
               dpfm_pkg::ACT_COMPLETE: begin
                  if (!stat.proc_ok || stat.mode != dpfm_pkg::MODE_RESIDENT) begin
                     cmd.status = dpfm_pkg::ST_NOT_RESIDENT;
                  end else begin
                     cmd.set_status = 1'b0;
                     cmd.ptr_reset  = 1'b1;
                     rel_swap_in    = 1'b0;
                     state_in       = dpfm_pkg::S_REL_RD;
                  end
               end
               default: begin
                  cmd.status = dpfm_pkg::ST_NOT_RESIDENT;
               end
            endcase
         end
         dpfm_pkg::S_ACC_CHK: begin
            if (stat.page_valid) begin
               cmd.hit_capture = 1'b1;
               cmd.set_status  = 1'b1;
               cmd.status      = dpfm_pkg::ST_HIT;
               state_in        = dpfm_pkg::S_RESULT;
            end else begin
               cmd.count_fault = 1'b1;
               if (stat.free_nonzero) begin
                  state_in = dpfm_pkg::S_FAULT_WR;
               end else begin
                  cmd.ptr_reset = 1'b1;
                  rel_swap_in   = 1'b1;
                  state_in      = dpfm_pkg::S_REL_RD;
               end
            end
         end
         dpfm_pkg::S_FAULT_WR: begin
            cmd.fault_write = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status      = dpfm_pkg::ST_FAULT;
            state_in        = dpfm_pkg::S_RESULT;
         end
         dpfm_pkg::S_REL_RD: begin
            state_in = dpfm_pkg::S_REL_WR;
         end
         dpfm_pkg::S_REL_WR: begin
            cmd.release_write = 1'b1;
            if (stat.sweep_last) begin
               state_in = dpfm_pkg::S_REL_END;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = dpfm_pkg::S_REL_RD;
            end
         end
         dpfm_pkg::S_REL_END: begin
            if (rel_swap_ff) begin
               cmd.finish_swapout = 1'b1;
               cmd.set_status     = 1'b1;
               cmd.status         = dpfm_pkg::ST_SWAPPED;
               state_in           = dpfm_pkg::S_RESULT;
            end else begin
               cmd.finish_complete = 1'b1;
               state_in            = dpfm_pkg::S_SWAPIN_CHK;
            end
         end
         dpfm_pkg::S_SWAPIN_CHK: begin
            if (stat.swap_pending && stat.free_ge_ess) begin
               cmd.do_swapin = 1'b1;
               cmd.ptr_reset = 1'b1;
               map_swapin_in = 1'b1;
               state_in      = dpfm_pkg::S_MAP_RD;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = dpfm_pkg::ST_COMPLETED;
               state_in       = dpfm_pkg::S_RESULT;
            end
         end
         dpfm_pkg::S_MAP_RD: begin
            state_in = dpfm_pkg::S_MAP_WR;
         end
         dpfm_pkg::S_MAP_WR: begin
            cmd.map_write = 1'b1;
            if (stat.map_last) begin
               cmd.set_status = 1'b1;
               state_in       = dpfm_pkg::S_RESULT;
               if (map_swapin_ff) begin
                  cmd.status = dpfm_pkg::ST_SWAPIN;
               end else begin
                  cmd.finish_admit = 1'b1;
                  cmd.status       = dpfm_pkg::ST_ADMITTED;
               end
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = dpfm_pkg::S_MAP_RD;
            end
         end
         dpfm_pkg::S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.result_load = 1'b1;
               state_in        = dpfm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dpfm_pkg::S_IDLE;
         end
      endcase
   end
endmodule

// ----- design/dpfm_datapath.sv -----
// Datapath of the frame manager: page tables, free-frame FIFO, swap queue, counters.
`timescale 1ns / 1ps
`include "demand_paging_frame_manager_assert.svh"
module dpfm_datapath #(
   parameter int PROCS           = 16,
   parameter int PAGES           = 2048,
   parameter int RESERVED_FRAMES = 4096,
   parameter int NUM_FRAMES      = 16384,
   parameter int ESSENTIAL_PAGES = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dpfm_pkg::cmd_type         cmd,
   output dpfm_pkg::stat_type        stat,
   dpfm_req_if.sink                  req_if,
   dpfm_rsp_if.source                rsp_if
);
   localparam int POOL_FRAMES = NUM_FRAMES - RESERVED_FRAMES;
   localparam int PAGE_DEPTH  = PROCS * PAGES;
   localparam int CLEAR_LEN   = (PAGE_DEPTH > POOL_FRAMES) ? PAGE_DEPTH : POOL_FRAMES;
   localparam int PMAW        = $clog2(PAGE_DEPTH);
   localparam int FQAW        = $clog2(POOL_FRAMES);
   localparam int FCW         = $clog2(POOL_FRAMES + 1);
   localparam int CLW         = $clog2(CLEAR_LEN);
   localparam int IW          = $clog2(PAGES);
   localparam int SIW         = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int PCW         = $clog2(PROCS + 1);
   localparam int FW          = dpfm_pkg::FRAME_W;
   localparam int CW          = dpfm_pkg::COUNT_W;

   dpfm_pkg::action_type           action_ff;
   logic [dpfm_pkg::PROC_W-1:0]    proc_ff;
   logic [dpfm_pkg::PAGE_W-1:0]    page_ff;
   logic [dpfm_pkg::PROC_W-1:0]    tgt_ff;
   logic [IW-1:0]                  i_ff;
   logic [CLW-1:0]                 clr_ff;
   logic [FQAW-1:0]                head_ff, tail_ff;
   logic [FCW-1:0]                 free_count_ff;
   logic [dpfm_pkg::PROC_W-1:0]    swap_q_ff [PROCS];
   logic [SIW-1:0]                 swap_head_ff;
   logic [PCW-1:0]                 swap_count_ff;
   dpfm_pkg::mode_type             mode_ff [PROCS];
   logic [PCW-1:0]                 admitted_ff, completed_ff;
   logic [CW-1:0]                  access_ff, fault_ff, swapout_ff;
   logic [dpfm_pkg::LEAST_W-1:0]   least_ff;
   dpfm_pkg::status_type           status_ff;
   logic [FW-1:0]                  frame_ff;
   logic [dpfm_pkg::PROC_W-1:0]    swapin_ff;
   logic                           rsp_valid_ff;
   logic [dpfm_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [FW-1:0]                  rsp_frame_ff;
   logic [dpfm_pkg::PROC_W-1:0]    rsp_swapin_ff;
   logic [dpfm_pkg::ACTIVE_W-1:0]  rsp_active_ff;
   logic [CW-1:0]                  rsp_access_ff, rsp_fault_ff, rsp_swap_ff;
   logic [dpfm_pkg::LEAST_W-1:0]   rsp_least_ff;

   logic [PMAW-1:0] access_addr, sweep_addr, page_waddr, page_raddr;
   logic [FW:0]     page_wdata, page_rdata;
   logic            page_we, free_we, clear_page, clear_free, give;
   logic [FQAW-1:0] free_waddr;
   logic [FW-1:0]   free_wdata, free_rdata;
   logic [PCW-1:0]  active, active_after_swap;
   logic [SIW:0]    swap_tail_sum;
   logic [SIW-1:0]  swap_tail;
   logic [dpfm_pkg::PROC_W-1:0] swap_front;

   assign access_addr = PMAW'(proc_ff) * PMAW'(PAGES) + PMAW'(page_ff);
   assign sweep_addr  = PMAW'(tgt_ff) * PMAW'(PAGES) + PMAW'(i_ff);
   assign clear_page  = cmd.clear_step && (32'(clr_ff) < PAGE_DEPTH);
   assign clear_free  = cmd.clear_step && (32'(clr_ff) < POOL_FRAMES);
   assign give        = cmd.release_write && page_rdata[FW];

   // Release and clear both write an empty entry; map and fault write a valid frame.
   assign page_we    = clear_page || cmd.map_write || cmd.fault_write || give;
   assign page_waddr = cmd.clear_step ? PMAW'(clr_ff) :
                       (cmd.fault_write ? access_addr : sweep_addr);
   assign page_wdata = (cmd.clear_step || cmd.release_write) ? '0 : {1'b1, free_rdata};
   assign page_raddr = cmd.page_rd_access ? access_addr : sweep_addr;

   assign free_we    = clear_free || give;
   assign free_waddr = cmd.clear_step ? FQAW'(clr_ff) : tail_ff;
   assign free_wdata = cmd.clear_step ? FW'(RESERVED_FRAMES + 32'(clr_ff)) : page_rdata[FW-1:0];

   dpfm_ram #(.WIDTH(FW + 1), .DEPTH(PAGE_DEPTH)) u_page_ram (
      .clock (clock),
      .we    (page_we),
      .waddr (page_waddr),
      .wdata (page_wdata),
      .raddr (page_raddr),
      .rdata (page_rdata)
   );

   dpfm_ram #(.WIDTH(FW), .DEPTH(POOL_FRAMES)) u_free_ram (
      .clock (clock),
      .we    (free_we),
      .waddr (free_waddr),
      .wdata (free_wdata),
      .raddr (head_ff),
      .rdata (free_rdata)
   );

   assign active            = admitted_ff - swap_count_ff - completed_ff;
   assign active_after_swap = active - PCW'(1);
   assign swap_tail_sum     = (SIW + 1)'(swap_head_ff) + (SIW + 1)'(swap_count_ff);
   assign swap_tail         = (32'(swap_tail_sum) >= PROCS) ?
                              SIW'(32'(swap_tail_sum) - PROCS) : SIW'(swap_tail_sum);
   assign swap_front        = swap_q_ff[swap_head_ff];

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= dpfm_pkg::action_type'(req_if.action);
         proc_ff   <= req_if.process;
         page_ff   <= req_if.page;
      end
      if (cmd.load_req) begin
         tgt_ff <= req_if.process;
      end else if (cmd.do_swapin) begin
         tgt_ff <= swap_front;
      end
      if (cmd.ptr_reset) begin
         i_ff <= '0;
      end else if (cmd.ptr_inc) begin
         i_ff <= i_ff + IW'(1);
      end
      if (cmd.load_req) begin
         frame_ff <= '0;
      end else if (cmd.hit_capture) begin
         frame_ff <= page_rdata[FW-1:0];
      end else if (cmd.fault_write) begin
         frame_ff <= free_rdata;
      end
      if (cmd.load_req) begin
         swapin_ff <= '0;
      end else if (cmd.do_swapin) begin
         swapin_ff <= swap_front;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.finish_swapout) begin
         swap_q_ff[swap_tail] <= tgt_ff;
      end
      if (cmd.result_load) begin
         rsp_status_ff <= status_ff;
         rsp_frame_ff  <= frame_ff;
         rsp_swapin_ff <= swapin_ff;
         rsp_active_ff <= dpfm_pkg::ACTIVE_W'(active);
         rsp_access_ff <= access_ff;
         rsp_fault_ff  <= fault_ff;
         rsp_swap_ff   <= swapout_ff;
         rsp_least_ff  <= least_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_count_ff <= FCW'(POOL_FRAMES);
         swap_head_ff  <= '0;
         swap_count_ff <= '0;
         admitted_ff   <= '0;
         completed_ff  <= '0;
         access_ff     <= '0;
         fault_ff      <= '0;
         swapout_ff    <= '0;
         least_ff      <= dpfm_pkg::NO_SWAP_YET;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < PROCS; k++) begin
            mode_ff[k] <= dpfm_pkg::MODE_NONE;
         end
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + CLW'(1);
         end
         // Take from the FIFO head, give back at the tail.
         if (cmd.map_write || cmd.fault_write) begin
            head_ff       <= (32'(head_ff) == POOL_FRAMES - 1) ? '0 : head_ff + FQAW'(1);
            free_count_ff <= free_count_ff - FCW'(1);
         end else if (give) begin
            tail_ff       <= (32'(tail_ff) == POOL_FRAMES - 1) ? '0 : tail_ff + FQAW'(1);
            free_count_ff <= free_count_ff + FCW'(1);
         end
         if (cmd.count_access && access_ff != '1) begin
            access_ff <= access_ff + CW'(1);
         end
         if (cmd.count_fault && fault_ff != '1) begin
            fault_ff <= fault_ff + CW'(1);
         end
         if (cmd.finish_admit) begin
            mode_ff[SIW'(tgt_ff)] <= dpfm_pkg::MODE_RESIDENT;
            admitted_ff           <= admitted_ff + PCW'(1);
         end
         if (cmd.finish_swapout) begin
            mode_ff[SIW'(tgt_ff)] <= dpfm_pkg::MODE_SWAPPED;
            swap_count_ff         <= swap_count_ff + PCW'(1);
            if (swapout_ff != '1) begin
               swapout_ff <= swapout_ff + CW'(1);
            end
            if (32'(active_after_swap) < 32'(least_ff)) begin
               least_ff <= dpfm_pkg::LEAST_W'(active_after_swap);
            end
         end
         if (cmd.finish_complete) begin
            mode_ff[SIW'(tgt_ff)] <= dpfm_pkg::MODE_DONE;
            completed_ff          <= completed_ff + PCW'(1);
         end
         if (cmd.do_swapin) begin
            mode_ff[SIW'(swap_front)] <= dpfm_pkg::MODE_RESIDENT;
            swap_head_ff  <= (32'(swap_head_ff) == PROCS - 1) ? '0 : swap_head_ff + SIW'(1);
            swap_count_ff <= swap_count_ff - PCW'(1);
         end
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.clear_last   = (32'(clr_ff) == CLEAR_LEN - 1);
   assign stat.req_valid    = req_if.valid;
   assign stat.action       = action_ff;
   assign stat.proc_ok      = (32'(proc_ff) < PROCS);
   assign stat.page_ok      = (32'(page_ff) < PAGES);
   assign stat.mode         = mode_ff[SIW'(proc_ff)];
   assign stat.free_ge_ess  = (32'(free_count_ff) >= ESSENTIAL_PAGES);
   assign stat.free_nonzero = (free_count_ff != '0);
   assign stat.page_valid   = page_rdata[FW];
   assign stat.sweep_last   = (32'(i_ff) == PAGES - 1);
   assign stat.map_last     = (32'(i_ff) == ESSENTIAL_PAGES - 1);
   assign stat.swap_pending = (swap_count_ff != '0);
   assign stat.rsp_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.status             = rsp_status_ff;
   assign rsp_if.frame              = rsp_frame_ff;
   assign rsp_if.swapped_in_process = rsp_swapin_ff;
   assign rsp_if.active_processes   = rsp_active_ff;
   assign rsp_if.access_total       = rsp_access_ff;
   assign rsp_if.fault_total        = rsp_fault_ff;
   assign rsp_if.swap_total         = rsp_swap_ff;
   assign rsp_if.min_active         = rsp_least_ff;

   `DPFM_ASSERT_IMP(a_free_bound, clock, reset, 1'b1, 32'(free_count_ff) <= POOL_FRAMES, "free count above pool size")
   `DPFM_ASSERT_IMP(a_take_nonempty, clock, reset, cmd.map_write || cmd.fault_write, free_count_ff != '0, "frame taken from empty FIFO")
   `DPFM_ASSERT_IMP(a_ptr_match, clock, reset, free_count_ff == '0 || 32'(free_count_ff) == POOL_FRAMES, head_ff == tail_ff, "FIFO pointers disagree with count")
   `DPFM_ASSERT_NEXT(a_rsp_loaded, clock, reset, cmd.result_load, rsp_valid_ff, "loaded result not presented")
endmodule

// ----- verif/demand_paging_frame_manager_tb.sv -----
// Self-checking testbench of the demand-paging frame manager with its own frame-table predictor.
`timescale 1ns / 1ps
module demand_paging_frame_manager_tb;

   localparam int PROCS           = 16;
   localparam int PAGES           = 2048;
   localparam int RESERVED_FRAMES = 4096;
   localparam int NUM_FRAMES      = 16384;
   localparam int ESSENTIAL_PAGES = 10;
   localparam int POOL_FRAMES     = NUM_FRAMES - RESERVED_FRAMES;
   localparam int STALL_LIMIT     = 200000;
   localparam int RANDOM_ITEMS    = 1700;
   localparam int FILL_ITEMS      = 120;
   localparam int EXP_DEPTH       = 16;
   localparam int FRAME_W         = dpfm_pkg::FRAME_W;
   localparam int PROC_W          = dpfm_pkg::PROC_W;
   localparam int PAGE_W          = dpfm_pkg::PAGE_W;
   localparam int ACTIVE_W        = dpfm_pkg::ACTIVE_W;
   localparam int COUNT_W         = dpfm_pkg::COUNT_W;
   localparam int LEAST_W         = dpfm_pkg::LEAST_W;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      dpfm_pkg::status_type status;
      logic [FRAME_W-1:0]   frame;
      logic [PROC_W-1:0]    swapin;
      logic [ACTIVE_W-1:0]  active;
      logic [COUNT_W-1:0]   accesses;
      logic [COUNT_W-1:0]   faults;
      logic [COUNT_W-1:0]   swapouts;
      logic [LEAST_W-1:0]   least;
   } frame_result_type;

   logic clock;
   logic reset;
   dpfm_req_if req_bus ();
   dpfm_rsp_if rsp_bus ();

   demand_paging_frame_manager u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus.sink),
      .rsp_if (rsp_bus.source)
   );

   // Predictor state
   logic [15:0]          ptab_model [PROCS*PAGES];
   logic [FRAME_W-1:0]   free_fifo [POOL_FRAMES];
   int                   free_rd, free_wr, free_cnt;
   logic [PROC_W-1:0]    swap_fifo [PROCS];
   int                   swap_rd, swap_cnt;
   dpfm_pkg::mode_type   proc_mode [PROCS];
   int                   admitted, completed;
   logic [31:0]          access_cnt, fault_cnt, swapout_cnt;
   logic [LEAST_W-1:0]   least_seen;

   frame_result_type expected_ring [EXP_DEPTH];
   int               exp_wr = 0;
   int               exp_rd = 0;
   int               error_count;
   int               stall_cycles = 0;
   bit               idle_on;
   int               next_page [PROCS];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s got %0h, want %0h", $realtime, field, got, want);
      error_count++;
   endtask

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == COUNT_MAX) ? v : v + 32'd1;
   endfunction

   task automatic take_frame(output logic [FRAME_W-1:0] f);
      f = free_fifo[free_rd];
      free_rd = (free_rd + 1) % POOL_FRAMES;
      free_cnt--;
   endtask

   task automatic release_frames(input int p);
      for (int i = 0; i < PAGES; i++) begin
         if (ptab_model[p*PAGES+i][15]) begin
            free_fifo[free_wr] = ptab_model[p*PAGES+i][FRAME_W-1:0];
            free_wr = (free_wr + 1) % POOL_FRAMES;
            free_cnt++;
            ptab_model[p*PAGES+i] = '0;
         end
      end
   endtask

   task automatic map_essential(input int p);
      logic [FRAME_W-1:0] f;
      for (int i = 0; i < ESSENTIAL_PAGES; i++) begin
         take_frame(f);
         ptab_model[p*PAGES+i] = {2'b10, f};
      end
   endtask

   task automatic predict_event(input dpfm_pkg::action_type act, input int p, input int pg,
                                output frame_result_type r);
      int idx;
      int q;
      logic [FRAME_W-1:0] f;
      r = '0;
      r.status = dpfm_pkg::ST_NOT_RESIDENT;
      idx = p*PAGES + pg;
      case (act)
         dpfm_pkg::ACT_ADMIT: begin
            if (proc_mode[p] != dpfm_pkg::MODE_NONE) r.status = dpfm_pkg::ST_NOT_RESIDENT;
            else if (free_cnt < ESSENTIAL_PAGES) r.status = dpfm_pkg::ST_NO_FRAMES;
            else begin
               map_essential(p);
               proc_mode[p] = dpfm_pkg::MODE_RESIDENT;
               admitted++;
               r.status = dpfm_pkg::ST_ADMITTED;
            end
         end
         dpfm_pkg::ACT_ACCESS: begin
            if (proc_mode[p] == dpfm_pkg::MODE_RESIDENT) begin
               access_cnt = sat_inc(access_cnt);
               if (ptab_model[idx][15]) begin
                  r.status = dpfm_pkg::ST_HIT;
                  r.frame = ptab_model[idx][FRAME_W-1:0];
               end else begin
                  fault_cnt = sat_inc(fault_cnt);
                  if (free_cnt > 0) begin
                     take_frame(f);
                     ptab_model[idx] = {2'b10, f};
                     r.frame = f;
                     r.status = dpfm_pkg::ST_FAULT;
                  end else begin
                     swapout_cnt = sat_inc(swapout_cnt);
                     release_frames(p);
                     proc_mode[p] = dpfm_pkg::MODE_SWAPPED;
                     swap_fifo[(swap_rd + swap_cnt) % PROCS] = PROC_W'(p);
                     swap_cnt++;
                     if (admitted - swap_cnt - completed < int'(least_seen))
                        least_seen = LEAST_W'(admitted - swap_cnt - completed);
                     r.status = dpfm_pkg::ST_SWAPPED;
                  end
               end
            end
         end
         dpfm_pkg::ACT_COMPLETE: begin
            if (proc_mode[p] == dpfm_pkg::MODE_RESIDENT) begin
               completed++;
               release_frames(p);
               proc_mode[p] = dpfm_pkg::MODE_DONE;
               r.status = dpfm_pkg::ST_COMPLETED;
               if (swap_cnt > 0 && free_cnt >= ESSENTIAL_PAGES) begin
                  q = int'(swap_fifo[swap_rd]);
                  swap_rd = (swap_rd + 1) % PROCS;
                  swap_cnt--;
                  map_essential(q);
                  proc_mode[q] = dpfm_pkg::MODE_RESIDENT;
                  r.swapin = PROC_W'(q);
                  r.status = dpfm_pkg::ST_SWAPIN;
               end
            end
         end
         default: r.status = dpfm_pkg::ST_NOT_RESIDENT;
      endcase
      r.active = ACTIVE_W'(admitted - swap_cnt - completed);
      r.accesses = access_cnt;
      r.faults = fault_cnt;
      r.swapouts = swapout_cnt;
      r.least = least_seen;
   endtask

   // Drive at the falling edge, take acceptance at the rising edge.
   task automatic send_item(input dpfm_pkg::action_type act, input int p, input int pg);
      frame_result_type r;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.action = act;
      req_bus.process = PROC_W'(p);
      req_bus.page = PAGE_W'(pg);
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
         @(negedge clock);
      end
      predict_event(act, p, pg, r);
      expected_ring[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   function automatic int pick_resident();
      int list [PROCS];
      int n;
      n = 0;
      for (int i = 0; i < PROCS; i++) begin
         if (proc_mode[i] == dpfm_pkg::MODE_RESIDENT) begin
            list[n] = i;
            n++;
         end
      end
      if (n == 0) return $urandom_range(0, PROCS-1);
      return list[$urandom_range(0, n-1)];
   endfunction

   task automatic test_directed();
      send_item(dpfm_pkg::ACT_ADMIT, 0, 0);
      send_item(dpfm_pkg::ACT_ADMIT, 0, 2047);
      send_item(dpfm_pkg::ACT_ACCESS, 0, 0);
      send_item(dpfm_pkg::ACT_ACCESS, 0, 9);
      send_item(dpfm_pkg::ACT_ACCESS, 0, 2047);
      send_item(dpfm_pkg::ACT_ACCESS, 0, 2047);
      send_item(dpfm_pkg::ACT_ACCESS, 0, 10);
      send_item(dpfm_pkg::ACT_INVALID, 15, 2047);
      send_item(dpfm_pkg::ACT_INVALID, 0, 0);
      send_item(dpfm_pkg::ACT_ACCESS, 5, 0);
      send_item(dpfm_pkg::ACT_COMPLETE, 5, 0);
      send_item(dpfm_pkg::ACT_ADMIT, 15, 1365);
      send_item(dpfm_pkg::ACT_ACCESS, 15, 682);
      send_item(dpfm_pkg::ACT_COMPLETE, 15, 0);
      send_item(dpfm_pkg::ACT_ACCESS, 15, 0);
      send_item(dpfm_pkg::ACT_ADMIT, 15, 0);
      send_item(dpfm_pkg::ACT_ADMIT, 1, 0);
      send_item(dpfm_pkg::ACT_ACCESS, 1, 1024);
   endtask

   task automatic test_admit_rest();
      for (int p = 2; p < PROCS-1; p++)
         send_item(dpfm_pkg::ACT_ADMIT, p, $urandom_range(0, 2047));
   endtask

   // Map fresh pages round robin over the resident processes.
   task automatic test_fill_pages();
      int p;
      int sent;
      p = 0;
      sent = 0;
      for (int i = 0; i < PROCS; i++) next_page[i] = 11;
      while (sent < FILL_ITEMS) begin
         if (proc_mode[p] == dpfm_pkg::MODE_RESIDENT && next_page[p] < PAGES) begin
            send_item(dpfm_pkg::ACT_ACCESS, p, next_page[p]);
            next_page[p]++;
            sent++;
         end
         p = (p + 1) % PROCS;
      end
   endtask

   task automatic test_swap_cycle();
      send_item(dpfm_pkg::ACT_ADMIT, 14, 0);
      send_item(dpfm_pkg::ACT_ACCESS, 2, next_page[2]);
      send_item(dpfm_pkg::ACT_ACCESS, 2, 0);
      send_item(dpfm_pkg::ACT_COMPLETE, 2, 0);
      send_item(dpfm_pkg::ACT_ACCESS, 3, 0);
      send_item(dpfm_pkg::ACT_COMPLETE, 3, 0);
      send_item(dpfm_pkg::ACT_ACCESS, 2, 5);
   endtask

   task automatic test_random();
      int roll;
      int p;
      int pg;
      int completes;
      dpfm_pkg::action_type act;
      completes = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n > RANDOM_ITEMS - 300) idle_on = 1'b0;
         roll = $urandom_range(0, 99);
         if (roll < 86) act = dpfm_pkg::ACT_ACCESS;
         else if (roll < 92) act = dpfm_pkg::ACT_ADMIT;
         else if (roll < 96 && completes < 6) act = dpfm_pkg::ACT_COMPLETE;
         else act = dpfm_pkg::ACT_INVALID;
         if (act == dpfm_pkg::ACT_COMPLETE) completes++;
         p = ($urandom_range(0, 9) != 0) ? pick_resident() : $urandom_range(0, PROCS-1);
         pg = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 31) : $urandom_range(0, 2047);
         send_item(act, p, pg);
      end
   endtask

   // Response backpressure in random bursts.
   initial begin
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      frame_result_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (exp_wr == exp_rd) begin
            report_mismatch("unexpected result, status", 32'(rsp_bus.status), 32'd0);
         end else begin
            w = expected_ring[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_bus.status !== w.status)
               report_mismatch("status", 32'(rsp_bus.status), 32'(w.status));
            if (rsp_bus.frame !== w.frame)
               report_mismatch("frame", 32'(rsp_bus.frame), 32'(w.frame));
            if (rsp_bus.swapped_in_process !== w.swapin)
               report_mismatch("swapped_in_process", 32'(rsp_bus.swapped_in_process),
                               32'(w.swapin));
            if (rsp_bus.active_processes !== w.active)
               report_mismatch("active_processes", 32'(rsp_bus.active_processes),
                               32'(w.active));
            if (rsp_bus.access_total !== w.accesses)
               report_mismatch("access_total", rsp_bus.access_total, w.accesses);
            if (rsp_bus.fault_total !== w.faults)
               report_mismatch("fault_total", rsp_bus.fault_total, w.faults);
            if (rsp_bus.swap_total !== w.swapouts)
               report_mismatch("swap_total", rsp_bus.swap_total, w.swapouts);
            if (rsp_bus.min_active !== w.least)
               report_mismatch("min_active", 32'(rsp_bus.min_active), 32'(w.least));
         end
      end
   end

   // Count cycles without any accepted item.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("demand_paging_frame_manager: mismatch");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = dpfm_pkg::ACT_ADMIT;
      req_bus.process = '0;
      req_bus.page = '0;
      error_count = 0;
      idle_on = 1'b1;
      for (int i = 0; i < PROCS*PAGES; i++) ptab_model[i] = '0;
      for (int i = 0; i < POOL_FRAMES; i++) free_fifo[i] = FRAME_W'(RESERVED_FRAMES + i);
      free_rd = 0;
      free_wr = 0;
      free_cnt = POOL_FRAMES;
      for (int i = 0; i < PROCS; i++) begin
         proc_mode[i] = dpfm_pkg::MODE_NONE;
         swap_fifo[i] = '0;
      end
      swap_rd = 0;
      swap_cnt = 0;
      admitted = 0;
      completed = 0;
      access_cnt = '0;
      fault_cnt = '0;
      swapout_cnt = '0;
      least_seen = dpfm_pkg::NO_SWAP_YET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_admit_rest();
      test_fill_pages();
      test_swap_cycle();
      test_random();

      while (exp_wr != exp_rd) @(posedge clock);
      repeat (40) @(posedge clock);
      if (exp_wr != exp_rd)
         report_mismatch("results left over", 32'(exp_wr - exp_rd), 32'd0);
      if (error_count == 0)
         $display("demand_paging_frame_manager: match");
      else
         $display("demand_paging_frame_manager: mismatch");
      $finish;
   end

endmodule
